### rtl/ndpad_pkg.sv
// Shared constants, word types and config field helpers for the N-d pad
// source address generator. No dependencies.
package ndpad_pkg;

	localparam int MAX_RANK    = 4;
	localparam int DIM_BITS    = 16;
	localparam int INDEX_BITS  = 32;
	localparam int NUM_COORDS  = 4;
	localparam int COORD_BITS  = 16;
	localparam int CFG_BITS    = 64;
	localparam int ADDR_BITS   = 5;
	localparam int REG_IDX_LSB = 3;
	localparam int REG_IDX_BITS = ADDR_BITS - REG_IDX_LSB;

	// shifted coordinate (signed), its magnitude and the reflect period 2(n-1)
	localparam int IC_BITS  = DIM_BITS + 2;
	localparam int ABS_BITS = DIM_BITS + 1;
	localparam int P_BITS   = DIM_BITS + 1;

	// remainder pipeline: REM_STEP restoring steps per stage
	localparam int REM_STEP   = 6;
	localparam int REM_STAGES = (ABS_BITS + REM_STEP - 1) / REM_STEP;
	localparam int DVD_BITS   = REM_STAGES * REM_STEP;

	localparam int RANK_BITS = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

	localparam logic [CFG_BITS-1:0] SIZES_RESET = CFG_BITS'(64'h1111_1111_1111_1111);

	typedef enum logic [1:0] {
		MODE_CONSTANT = 2'd0,
		MODE_EDGE     = 2'd1,
		MODE_REFLECT  = 2'd2
	} pad_mode_t;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_PAD_MODE    = REG_IDX_BITS'(0),
		REG_PAD_VALUE   = REG_IDX_BITS'(1),
		REG_INPUT_SIZES = REG_IDX_BITS'(2),
		REG_BEGIN_PADS  = REG_IDX_BITS'(3)
	} reg_idx_t;

	typedef logic [NUM_COORDS-1:0][COORD_BITS-1:0] coord_arr_t;
	typedef logic [RANK_BITS-1:0] rank_idx_t;

	// per-dimension state while the reflect remainder is worked out
	typedef struct packed {
		logic [IC_BITS-1:0]  ic;
		logic                oob;
		logic [DVD_BITS-1:0] dvd;
		logic [P_BITS-1:0]   rem;
	} dim_t;

	typedef struct packed {
		dim_t [MAX_RANK-1:0] dim;
	} rem_item_t;

	// linear index accumulation word
	typedef struct packed {
		logic [INDEX_BITS-1:0]              lin;
		logic [MAX_RANK-1:0][DIM_BITS-1:0] coord;
		logic                               use_const;
	} mac_item_t;

	// field of dimension d in a packed register; absent when it does not fit
	function automatic logic [DIM_BITS-1:0] dim_field(input logic [CFG_BITS-1:0] reg_val,
			input int d, input logic [DIM_BITS-1:0] absent);
		logic [CFG_BITS-1:0] sh;
		sh = reg_val >> ((MAX_RANK - 1 - d) * DIM_BITS);
		if ((MAX_RANK - d) * DIM_BITS > CFG_BITS) begin
			return absent;
		end
		return sh[DIM_BITS-1:0];
	endfunction

	// input size, zero read as one
	function automatic logic [DIM_BITS-1:0] dim_size(input logic [CFG_BITS-1:0] sizes,
			input int d);
		logic [DIM_BITS-1:0] f;
		f = dim_field(sizes, d, DIM_BITS'(1));
		return (f == '0) ? DIM_BITS'(1) : f;
	endfunction

	function automatic logic [DIM_BITS-1:0] dim_pad(input logic [CFG_BITS-1:0] pads,
			input int d);
		return dim_field(pads, d, '0);
	endfunction

	function automatic logic [P_BITS-1:0] dim_period(input logic [CFG_BITS-1:0] sizes,
			input int d);
		return {dim_size(sizes, d) - DIM_BITS'(1), 1'b0};
	endfunction

endpackage

### rtl/ndpad_offset.sv
// First pipeline stage: subtracts the begin pads and flags out-of-range coordinates.
// Depends on ndpad_pkg.
module ndpad_offset (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  ndpad_pkg::coord_arr_t        coord,
	input  logic [ndpad_pkg::CFG_BITS-1:0] sizes,
	input  logic [ndpad_pkg::CFG_BITS-1:0] pads,
	output logic                         out_valid,
	output ndpad_pkg::rem_item_t         out_item,
	input  logic                         out_ready
);
	import ndpad_pkg::*;

	logic      vld_s1;
	rem_item_t item_s1;
	rem_item_t nxt;

	always_comb begin
		logic [DIM_BITS-1:0] oc;
		logic [DIM_BITS-1:0] pad;
		logic [DIM_BITS-1:0] n;
		logic [IC_BITS-1:0]  ic;
		logic [IC_BITS-1:0]  mag;
		nxt = '0;
		for (int d = 0; d < MAX_RANK; d++) begin
			oc = '0;
			if (d < NUM_COORDS) begin
				oc = coord[d][DIM_BITS-1:0];
			end
			pad = dim_pad(pads, d);
			n   = dim_size(sizes, d);
			ic  = {(IC_BITS-DIM_BITS)'(0), oc}
				- {{(IC_BITS-DIM_BITS){pad[DIM_BITS-1]}}, pad};
			mag = ic[IC_BITS-1] ? (~ic + IC_BITS'(1)) : ic;
			nxt.dim[d].ic  = ic;
			nxt.dim[d].oob = ic[IC_BITS-1]
				|| (ic[IC_BITS-2:0] >= (IC_BITS-1)'(n));
			// dividend gets leading zeros up to the full remainder pipe width
			nxt.dim[d].dvd = DVD_BITS'(mag[ABS_BITS-1:0]);
			nxt.dim[d].rem = '0;
		end
	end

	assign in_ready  = !vld_s1 || out_ready;
	assign out_valid = vld_s1;
	assign out_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= nxt;
		end
	end

endmodule

### rtl/ndpad_rem_stage.sv
// One stage of the pipelined restoring remainder |ic| mod 2(n-1), all lanes.
// Depends on ndpad_pkg.
module ndpad_rem_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  ndpad_pkg::rem_item_t         in_item,
	input  logic [ndpad_pkg::CFG_BITS-1:0] sizes,
	output logic                         out_valid,
	output ndpad_pkg::rem_item_t         out_item,
	input  logic                         out_ready
);
	import ndpad_pkg::*;

	logic      vld_s2;
	rem_item_t item_s2;
	rem_item_t nxt;

	always_comb begin
		logic [P_BITS-1:0]   p;
		logic [P_BITS-1:0]   rem;
		logic [DVD_BITS-1:0] dvd;
		logic [P_BITS:0]     sh;
		nxt = in_item;
		for (int d = 0; d < MAX_RANK; d++) begin
			p   = dim_period(sizes, d);
			rem = in_item.dim[d].rem;
			dvd = in_item.dim[d].dvd;
			for (int j = 0; j < REM_STEP; j++) begin
				sh  = {rem, dvd[DVD_BITS-1]};
				dvd = dvd << 1;
				if (sh >= {1'b0, p}) begin
					rem = P_BITS'(sh - {1'b0, p});
				end else begin
					rem = P_BITS'(sh);
				end
			end
			nxt.dim[d].rem = rem;
			nxt.dim[d].dvd = dvd;
		end
	end

	assign in_ready  = !vld_s2 || out_ready;
	assign out_valid = vld_s2;
	assign out_item  = item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (in_ready) begin
			vld_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s2 <= nxt;
		end
	end

endmodule

### rtl/ndpad_fold.sv
// Resolves each coordinate by pad mode (in range, clamp, reflect, constant).
// Depends on ndpad_pkg.
module ndpad_fold (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  ndpad_pkg::rem_item_t         in_item,
	input  logic [ndpad_pkg::CFG_BITS-1:0] sizes,
	input  logic [1:0]                   mode,
	output logic                         out_valid,
	output ndpad_pkg::mac_item_t         out_item,
	input  logic                         out_ready
);
	import ndpad_pkg::*;

	logic      vld_s3;
	mac_item_t item_s3;
	mac_item_t nxt;

	always_comb begin
		logic [DIM_BITS-1:0] n;
		logic [P_BITS-1:0]   p;
		logic [P_BITS-1:0]   r;
		logic                any_oob;
		logic                use_const;
		nxt     = '0;
		any_oob = 1'b0;
		for (int d = 0; d < MAX_RANK; d++) begin
			n = dim_size(sizes, d);
			p = dim_period(sizes, d);
			r = in_item.dim[d].rem;
			any_oob = any_oob || in_item.dim[d].oob;
			nxt.coord[d] = in_item.dim[d].ic[DIM_BITS-1:0];
			if (in_item.dim[d].oob) begin
				case (mode)
					MODE_EDGE: begin
						nxt.coord[d] = in_item.dim[d].ic[IC_BITS-1] ? '0 : n - DIM_BITS'(1);
					end
					MODE_REFLECT: begin
						if (n == DIM_BITS'(1)) begin
							nxt.coord[d] = '0;
						end else if (r < P_BITS'(n)) begin
							nxt.coord[d] = r[DIM_BITS-1:0];
						end else begin
							nxt.coord[d] = DIM_BITS'(p - r);
						end
					end
					default: begin
						nxt.coord[d] = '0;
					end
				endcase
			end
		end
		use_const = any_oob && (mode != MODE_EDGE) && (mode != MODE_REFLECT);
		// zero coordinates make the accumulated index come out as 0
		if (use_const) begin
			nxt.coord = '0;
		end
		nxt.use_const = use_const;
		nxt.lin       = INDEX_BITS'(nxt.coord[0]);
	end

	assign in_ready  = !vld_s3 || out_ready;
	assign out_valid = vld_s3;
	assign out_item  = item_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (in_ready) begin
			vld_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s3 <= nxt;
		end
	end

endmodule

### rtl/ndpad_mac_stage.sv
// One Horner step of the row-major index: lin * n[dim_sel] + coord[dim_sel].
// Depends on ndpad_pkg.
module ndpad_mac_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ndpad_pkg::rank_idx_t         dim_sel,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  ndpad_pkg::mac_item_t         in_item,
	input  logic [ndpad_pkg::CFG_BITS-1:0] sizes,
	output logic                         out_valid,
	output ndpad_pkg::mac_item_t         out_item,
	input  logic                         out_ready
);
	import ndpad_pkg::*;

	logic      vld_s4;
	mac_item_t item_s4;
	mac_item_t nxt;
	logic [INDEX_BITS+DIM_BITS-1:0] prod;

	always_comb begin
		prod = {DIM_BITS'(0), in_item.lin}
			* {INDEX_BITS'(0), dim_size(sizes, int'(dim_sel))};
		nxt     = in_item;
		nxt.lin = INDEX_BITS'(prod) + INDEX_BITS'(in_item.coord[dim_sel]);
	end

	assign in_ready  = !vld_s4 || out_ready;
	assign out_valid = vld_s4;
	assign out_item  = item_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (in_ready) begin
			vld_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s4 <= nxt;
		end
	end

endmodule

### rtl/nd_pad_source_address.sv
// Top level of the N-d pad source address generator: config registers and the
// pipeline. Depends on ndpad_pkg and all ndpad_* stage modules.
//
// Takes one output-tensor coordinate word per cycle while in_stall is low and
// returns one word with the row-major input index, a use-constant flag and the
// fill value bits. Sustained rate is one word per clock with no bubbles
// while out_stall stays low. The pipeline at the default build has one offset
// stage, three remainder stages (6 restoring steps each, all dimensions in
// parallel lanes), one fold stage and three multiply-add stages (one per
// inner dimension, 32x16 multiplier each). Every stage holds its word while
// out_stall is high and fills empty slots, so in_stall only rises when the
// pipe is full. Config registers sit on an APB port at 8-byte spacing:
// 0x00 pad_mode, 0x08 pad_value_bits, 0x10 input_sizes, 0x18 begin_pads;
// write them only while the pipe is drained. fill_bits follows the register.
module nd_pad_source_address (
	input  logic                              clk,
	input  logic                              arst_n,
	// config port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ndpad_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [ndpad_pkg::CFG_BITS-1:0]    pwdata,
	output logic [ndpad_pkg::CFG_BITS-1:0]    prdata,
	output logic                              pready,
	// coordinate words in
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ndpad_pkg::COORD_BITS-1:0]  out_coord_0,
	input  logic [ndpad_pkg::COORD_BITS-1:0]  out_coord_1,
	input  logic [ndpad_pkg::COORD_BITS-1:0]  out_coord_2,
	input  logic [ndpad_pkg::COORD_BITS-1:0]  out_coord_3,
	// address words out
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [31:0]                       source_index,
	output logic                              use_constant,
	output logic [31:0]                       fill_bits
);
	import ndpad_pkg::*;

	logic [1:0]          pad_mode_q;
	logic [31:0]         pad_value_q;
	logic [CFG_BITS-1:0] input_sizes_q;
	logic [CFG_BITS-1:0] begin_pads_q;
	reg_idx_t            reg_idx;
	logic                reg_wr;

	coord_arr_t coord;

	// remainder chain: index 0 is the offset stage output
	rem_item_t rem_chain [REM_STAGES+1];
	logic      rem_vld   [REM_STAGES+1];
	logic      rem_rdy   [REM_STAGES+1];

	// multiply-add chain: index 0 is the fold stage output, last is the output reg
	mac_item_t mac_chain [MAX_RANK];
	logic      mac_vld   [MAX_RANK];
	logic      mac_rdy   [MAX_RANK];
	logic      fold_in_rdy;

	// ---------------- config registers ----------------
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_BITS-1:REG_IDX_LSB]);
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_mode_q    <= MODE_CONSTANT;
			pad_value_q   <= '0;
			input_sizes_q <= SIZES_RESET;
			begin_pads_q  <= '0;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_PAD_MODE:    pad_mode_q    <= pwdata[1:0];
				REG_PAD_VALUE:   pad_value_q   <= pwdata[31:0];
				REG_INPUT_SIZES: input_sizes_q <= pwdata;
				REG_BEGIN_PADS:  begin_pads_q  <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PAD_MODE:    prdata = CFG_BITS'(pad_mode_q);
			REG_PAD_VALUE:   prdata = CFG_BITS'(pad_value_q);
			REG_INPUT_SIZES: prdata = input_sizes_q;
			REG_BEGIN_PADS:  prdata = begin_pads_q;
			default:         prdata = '0;
		endcase
	end

	// ---------------- pipeline ----------------
	assign coord[0] = out_coord_0;
	assign coord[1] = out_coord_1;
	assign coord[2] = out_coord_2;
	assign coord[3] = out_coord_3;

	ndpad_offset u_offset (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (rem_rdy[0]),
		.coord     (coord),
		.sizes     (input_sizes_q),
		.pads      (begin_pads_q),
		.out_valid (rem_vld[0]),
		.out_item  (rem_chain[0]),
		.out_ready (rem_rdy[1])
	);
	assign in_stall = !rem_rdy[0];

	for (genvar k = 0; k < REM_STAGES; k++) begin : g_rem
		logic nxt_rdy;
		if (k == REM_STAGES - 1) begin : g_last
			assign nxt_rdy = fold_in_rdy;
		end else begin : g_mid
			assign nxt_rdy = rem_rdy[k+2];
		end
		ndpad_rem_stage u_rem (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (rem_vld[k]),
			.in_ready  (rem_rdy[k+1]),
			.in_item   (rem_chain[k]),
			.sizes     (input_sizes_q),
			.out_valid (rem_vld[k+1]),
			.out_item  (rem_chain[k+1]),
			.out_ready (nxt_rdy)
		);
	end

	ndpad_fold u_fold (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rem_vld[REM_STAGES]),
		.in_ready  (fold_in_rdy),
		.in_item   (rem_chain[REM_STAGES]),
		.sizes     (input_sizes_q),
		.mode      (pad_mode_q),
		.out_valid (mac_vld[0]),
		.out_item  (mac_chain[0]),
		.out_ready (mac_rdy[0])
	);

	// mac_rdy[k] is the ready of whatever consumes mac_chain[k]
	for (genvar k = 1; k < MAX_RANK; k++) begin : g_mac
		ndpad_mac_stage u_mac (
			.clk       (clk),
			.arst_n    (arst_n),
			.dim_sel   (RANK_BITS'(k)),
			.in_valid  (mac_vld[k-1]),
			.in_ready  (mac_rdy[k-1]),
			.in_item   (mac_chain[k-1]),
			.sizes     (input_sizes_q),
			.out_valid (mac_vld[k]),
			.out_item  (mac_chain[k]),
			.out_ready (mac_rdy[k])
		);
	end
	assign mac_rdy[MAX_RANK-1] = !out_stall;

	// ---------------- result word ----------------
	// last stage register is the output register; index is already 0 for fill
	assign out_valid    = mac_vld[MAX_RANK-1];
	assign source_index = 32'(mac_chain[MAX_RANK-1].lin);
	assign use_constant = mac_chain[MAX_RANK-1].use_const;
	assign fill_bits    = pad_value_q;

endmodule
